/* rtl/ehc_pkg.sv */
// ehc_pkg: widths, header constants and protocol class codes for the
// ethernet header classifier; no dependencies
`timescale 1ns / 1ps

package ehc_pkg;

  localparam int unsigned MacW    = 48;
  localparam int unsigned TypeW   = 16;
  localparam int unsigned PosW    = 5;
  localparam int unsigned OutDataW = 136;

  localparam logic [TypeW-1:0] TpidDot1q     = 16'h8100;
  localparam logic [TypeW-1:0] MaxLengthType = 16'd1500;
  localparam logic [TypeW-1:0] TypeArp       = 16'h0806;
  localparam logic [TypeW-1:0] TypeIpv4      = 16'h0800;
  localparam logic [TypeW-1:0] TypeIpv6      = 16'h86DD;
  localparam logic [23:0]      LlcSnapHdr    = 24'hAAAA03;
  localparam logic [6:0]       LlcAddrMask   = 7'h7f;

  localparam logic [PosW-1:0] PosDstEnd  = 5'd6;
  localparam logic [PosW-1:0] PosSrcEnd  = 5'd12;
  localparam logic [PosW-1:0] PosTypeEnd = 5'd14;
  localparam logic [PosW-1:0] PosTagEnd  = 5'd16;
  localparam logic [PosW-1:0] PosTagType = 5'd18;
  localparam logic [PosW-1:0] PosMax     = 5'd31;
  localparam logic [PosW-1:0] OffUntag   = 5'd14;
  localparam logic [PosW-1:0] OffTag     = 5'd18;
  localparam logic [PosW-1:0] OffSnapAdd = 5'd8;

  typedef enum logic [1:0] {
    PROTO_ARP   = 2'd0,
    PROTO_IPV4  = 2'd1,
    PROTO_IPV6  = 2'd2,
    PROTO_OTHER = 2'd3
  } proto_e;

  function automatic proto_e classify(input logic [TypeW-1:0] t);
    proto_e c;
    c = PROTO_OTHER;
    if (t == TypeArp) c = PROTO_ARP;
    else if (t == TypeIpv4) c = PROTO_IPV4;
    else if (t == TypeIpv6) c = PROTO_IPV6;
    return c;
  endfunction

endpackage

/* rtl/ethernet_header_classifier_top.sv */
// ethernet_header_classifier_top: parses mac addresses, 802.1q tag, ethertype
// and llc/snap headers from a receive byte stream; depends on ehc_pkg
//
// channel   dir  payload
// s_axis    in   tdata[7:0] frame byte, tlast end of frame
// m_axis    out  tdata header fields (see port), tuser {status, proto class}
//
// one byte per cycle while ready, result registered from the deciding byte
// at most one result per frame, bytes after the decision give nothing
// s_axis_tready_o drops only while a result waits and m_axis_tready_i is low
// rst_ni clears all frame state and the output valid flag
`timescale 1ns / 1ps

module ethernet_header_classifier_top
  import ehc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,  // frame_byte
  input  logic                s_axis_tlast_i,  // end_of_frame
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // dest_mac[47:0], source_mac[95:48], vlan_tci[111:96], has_vlan[112],
  // frame_type[128:113], payload_offset[133:129], zero pad[135:134]
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // proto_class[1:0], header_status[2]
  output logic [2:0]          m_axis_tuser_o
);

  logic [PosW-1:0]  pos_q, pos_d;
  logic             done_q, done_d;
  logic [MacW-1:0]  dest_q, dest_d;
  logic [MacW-1:0]  src_q, src_d;
  logic [TypeW-1:0] type_q, type_d;
  logic [TypeW-1:0] tci_q, tci_d;
  logic             tag_q, tag_d;
  logic [23:0]      llc_q, llc_d;

  logic             s_acc;
  logic             res_fire;
  logic [MacW-1:0]  res_dest, res_src;
  logic [TypeW-1:0] res_tci, res_type;
  logic             res_tag, res_status;
  proto_e           res_class;
  logic [PosW-1:0]  res_off;
  logic [PosW-1:0]  hs, rel;
  logic             type_ready;

  logic             out_valid_q;
  logic [MacW-1:0]  out_dest_q, out_src_q;
  logic [TypeW-1:0] out_tci_q, out_type_q;
  logic             out_tag_q, out_status_q;
  proto_e           out_class_q;
  logic [PosW-1:0]  out_off_q;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    pos_d      = pos_q;
    done_d     = done_q;
    dest_d     = dest_q;
    src_d      = src_q;
    type_d     = type_q;
    tci_d      = tci_q;
    tag_d      = tag_q;
    llc_d      = llc_q;
    res_fire   = 1'b0;
    res_type   = '0;
    res_class  = PROTO_OTHER;
    res_off    = '0;
    res_status = 1'b0;
    type_ready = 1'b0;
    hs         = tag_q ? OffTag : OffUntag;
    rel        = pos_q - hs;
    if (s_acc && !done_q) begin
      if (pos_q < PosDstEnd) begin
        dest_d = {dest_q[MacW-9:0], s_axis_tdata_i};
      end else if (pos_q < PosSrcEnd) begin
        src_d = {src_q[MacW-9:0], s_axis_tdata_i};
      end else if (pos_q < PosTypeEnd) begin
        type_d = {type_q[7:0], s_axis_tdata_i};
        if (pos_q == PosTypeEnd - 5'd1) begin
          if (type_d == TpidDot1q) tag_d = 1'b1;
          else type_ready = 1'b1;
        end
      end else if (tag_q && pos_q < PosTagEnd) begin
        tci_d = {tci_q[7:0], s_axis_tdata_i};
      end else if (tag_q && pos_q < PosTagType) begin
        type_d = {type_q[7:0], s_axis_tdata_i};
        if (pos_q == PosTagType - 5'd1) type_ready = 1'b1;
      end else if (rel < 5'd3) begin
        llc_d = {llc_q[15:0], s_axis_tdata_i};
        if (rel == 5'd2) begin
          if (llc_d == LlcSnapHdr) begin
            llc_d = '0;
          end else begin
            res_fire  = 1'b1;
            res_type  = {9'd0, llc_d[22:16] & LlcAddrMask};
            res_class = classify(res_type);
            res_off   = hs;
            done_d    = 1'b1;
          end
        end
      end else if (rel < 5'd8) begin
        // snap: oui skipped, type from the last two bytes
        if (rel >= 5'd6) llc_d = {8'd0, llc_q[7:0], s_axis_tdata_i};
        if (rel == 5'd7) begin
          res_fire  = 1'b1;
          res_type  = llc_d[15:0];
          res_class = classify(res_type);
          res_off   = hs + OffSnapAdd;
          done_d    = 1'b1;
        end
      end
      if (type_ready && type_d > MaxLengthType) begin
        res_fire  = 1'b1;
        res_type  = type_d;
        res_class = classify(type_d);
        res_off   = hs;
        done_d    = 1'b1;
      end
      if (!done_d && pos_q != PosMax) pos_d = pos_q + 5'd1;
      if (s_axis_tlast_i && !done_d) begin
        res_fire   = 1'b1;
        res_type   = '0;
        res_class  = PROTO_OTHER;
        res_off    = '0;
        res_status = 1'b1;
      end
    end
    res_dest = dest_d;
    res_src  = src_d;
    res_tci  = tci_d;
    res_tag  = tag_d;
    if (s_acc && s_axis_tlast_i) begin
      pos_d  = '0;
      done_d = 1'b0;
      dest_d = '0;
      src_d  = '0;
      type_d = '0;
      tci_d  = '0;
      tag_d  = 1'b0;
      llc_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      done_q <= 1'b0;
      dest_q <= '0;
      src_q  <= '0;
      type_q <= '0;
      tci_q  <= '0;
      tag_q  <= 1'b0;
      llc_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      done_q <= done_d;
      dest_q <= dest_d;
      src_q  <= src_d;
      type_q <= type_d;
      tci_q  <= tci_d;
      tag_q  <= tag_d;
      llc_q  <= llc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_acc && res_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc && res_fire) begin
      out_dest_q   <= res_dest;
      out_src_q    <= res_src;
      out_tci_q    <= res_tci;
      out_tag_q    <= res_tag;
      out_type_q   <= res_type;
      out_class_q  <= res_class;
      out_off_q    <= res_off;
      out_status_q <= res_status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_off_q, out_type_q, out_tag_q, out_tci_q,
                            out_src_q, out_dest_q};
  assign m_axis_tuser_o  = {out_status_q, out_class_q};

  // truncated results carry no type information
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q) |-> (out_off_q == '0 && out_class_q == PROTO_OTHER))
    else $error("truncated result with payload offset or class");

  // complete results start the payload at one of the legal offsets
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_status_q) |->
      (out_off_q == 5'd14 || out_off_q == 5'd18 || out_off_q == 5'd22 ||
       out_off_q == 5'd26))
    else $error("bad payload offset");

  // a frame end returns the parser to its start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && s_axis_tlast_i) |=> (pos_q == '0 && !done_q && !tag_q))
    else $error("frame state not cleared after last transfer");

  // no header is decided before the type field is complete
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (pos_q >= PosTypeEnd - 5'd1))
    else $error("header decided too early");

endmodule
